### src/rsl_pkg.sv
// ----------------------------------------------------------------------------
// rsl_pkg: shared types and constants of the radial spotlight block
// Fixed-point constants of the falloff curve, the payload that travels
// through the square-root cells, and the configuration register indexes.
// ----------------------------------------------------------------------------
package rsl_pkg;

    // Configuration registers: signed center coordinates.
    localparam int CFG_W = 13;

    typedef enum logic [0:0] {
        CFG_CENTER_X = 1'b0,
        CFG_CENTER_Y = 1'b1
    } t_cfg_reg;

    // Square-root datapath: the radicand is d2 << 16 with d2 <= 25600,
    // so it fits in 31 bits and the Q8.8 root in 16 bits.
    localparam int RAD_W  = 32;
    localparam int ROOT_W = 16;
    localparam int REM_W  = 18;
    localparam int NEAR_W = 15;

    localparam int unsigned FAR_LIMIT_SQ = 25600;

    // Factor in units of 2^-16.
    localparam int FACTOR_W = 17;
    localparam logic [FACTOR_W-1:0] FACTOR_ONE = 17'd65536;
    localparam logic [FACTOR_W-1:0] FACTOR_FAR = 17'd13107;

    // floor(root * 32 / 25) == floor(root * SLOPE_RECIP / 2^21) for every
    // root below 2^16 (reciprocal rounded up, error stays under one).
    localparam int SLOPE_RECIP_W = 22;
    localparam logic [SLOPE_RECIP_W-1:0] SLOPE_RECIP = 22'd2684355;
    localparam int SLOPE_SHIFT  = 21;
    localparam int SLOPE_PROD_W = ROOT_W + SLOPE_RECIP_W;
    localparam int FACTOR_SHIFT = 16;

    // Partial state of one item inside the square-root chain.
    typedef struct packed {
        logic              far;
        logic [RAD_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } t_root_data;

endpackage

### src/rsl_front.sv
// ----------------------------------------------------------------------------
// rsl_front: distance front end
// Forms the offsets from the center, squares them and sums them, then
// flags far pixels and prepares the radicand for the square-root chain.
// ----------------------------------------------------------------------------
module rsl_front
    import rsl_pkg::*;
#(
    parameter int COORD_W = 12,
    parameter int LUM_W   = 17
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic signed [CFG_W-1:0] i_center_x,
    input  logic signed [CFG_W-1:0] i_center_y,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [COORD_W-1:0]      i_pixel_x,
    input  logic [COORD_W-1:0]      i_pixel_y,
    input  logic [LUM_W-1:0]        i_lum,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [LUM_W-1:0]        o_lum,
    output t_root_data              o_data
);

    localparam int DIFF_W = ((COORD_W + 1 > CFG_W) ? COORD_W + 1 : CFG_W) + 1;
    localparam int SQ_W   = 2 * DIFF_W - 2;
    localparam int D2_W   = SQ_W + 1;

    logic [2:0] r_v;
    logic [2:0] st;

    logic signed [DIFF_W-1:0] r_dx;
    logic signed [DIFF_W-1:0] r_dy;
    logic [LUM_W-1:0]         r_lum0;
    logic [SQ_W-1:0]          r_sx;
    logic [SQ_W-1:0]          r_sy;
    logic [LUM_W-1:0]         r_lum1;
    logic [LUM_W-1:0]         r_lum2;
    t_root_data               r_data;

    logic signed [DIFF_W-1:0]   n_dx;
    logic signed [DIFF_W-1:0]   n_dy;
    logic signed [2*DIFF_W-1:0] sq_x;
    logic signed [2*DIFF_W-1:0] sq_y;
    logic [D2_W-1:0]            d2;
    t_root_data                 n_data;

    // A stage holds only while it is full and the stage after it holds.
    assign st[2]   = r_v[2] && i_stall;
    assign st[1]   = r_v[1] && st[2];
    assign st[0]   = r_v[0] && st[1];
    assign o_stall = st[0];

    assign n_dx = DIFF_W'($signed({1'b0, i_pixel_x})) - DIFF_W'(i_center_x);
    assign n_dy = DIFF_W'($signed({1'b0, i_pixel_y})) - DIFF_W'(i_center_y);

    assign sq_x = (2*DIFF_W)'(r_dx) * (2*DIFF_W)'(r_dx);
    assign sq_y = (2*DIFF_W)'(r_dy) * (2*DIFF_W)'(r_dy);

    always_comb begin
        d2          = {1'b0, r_sx} + {1'b0, r_sy};
        n_data.far  = (d2 > D2_W'(FAR_LIMIT_SQ));
        n_data.rad  = {1'b0, d2[NEAR_W-1:0], {(RAD_W - NEAR_W - 1){1'b0}}};
        n_data.rem  = '0;
        n_data.root = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (!st[0]) r_v[0] <= i_valid;
            if (!st[1]) r_v[1] <= r_v[0];
            if (!st[2]) r_v[2] <= r_v[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!st[0]) begin
            r_dx   <= n_dx;
            r_dy   <= n_dy;
            r_lum0 <= i_lum;
        end
        if (!st[1]) begin
            r_sx   <= sq_x[SQ_W-1:0];
            r_sy   <= sq_y[SQ_W-1:0];
            r_lum1 <= r_lum0;
        end
        if (!st[2]) begin
            r_data <= n_data;
            r_lum2 <= r_lum1;
        end
    end

    assign o_valid = r_v[2];
    assign o_lum   = r_lum2;
    assign o_data  = r_data;

endmodule

### src/rsl_root_cell.sv
// ----------------------------------------------------------------------------
// rsl_root_cell: one digit of the restoring square root
// Brings down two radicand bits, tries the next root bit and passes the
// updated remainder and partial root to the next cell.
// ----------------------------------------------------------------------------
module rsl_root_cell
    import rsl_pkg::*;
#(
    parameter int LUM_W = 17
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [LUM_W-1:0] i_lum,
    input  t_root_data       i_data,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [LUM_W-1:0] o_lum,
    output t_root_data       o_data
);

    logic             r_valid;
    logic [LUM_W-1:0] r_lum;
    t_root_data       r_data;

    logic [REM_W-1:0] rem2;
    logic [REM_W-1:0] trial;
    logic             fits;
    t_root_data       n_data;

    assign o_stall = r_valid && i_stall;

    always_comb begin
        rem2        = {i_data.rem[REM_W-3:0], i_data.rad[RAD_W-1 -: 2]};
        trial       = {i_data.root, 2'b01};
        fits        = (rem2 >= trial);
        n_data.far  = i_data.far;
        n_data.rad  = {i_data.rad[RAD_W-3:0], 2'b00};
        n_data.rem  = fits ? (rem2 - trial) : rem2;
        n_data.root = {i_data.root[ROOT_W-2:0], fits};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall) begin
            r_lum  <= i_lum;
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_lum   = r_lum;
    assign o_data  = r_data;

endmodule

### src/rsl_back.sv
// ----------------------------------------------------------------------------
// rsl_back: falloff factor and luminance scaling
// Turns the Q8.8 distance into the linear factor (or the far factor) and
// scales the luminance by it, truncating the product.
// ----------------------------------------------------------------------------
module rsl_back
    import rsl_pkg::*;
#(
    parameter int LUM_W = 17
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [LUM_W-1:0]  i_lum,
    input  logic              i_far,
    input  logic [ROOT_W-1:0] i_root,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [LUM_W-1:0]  o_lum
);

    logic [2:0] r_v;
    logic [2:0] st;

    logic [SLOPE_PROD_W-1:0] r_prod;
    logic                    r_far;
    logic [LUM_W-1:0]        r_lum0;
    logic [FACTOR_W-1:0]     r_factor;
    logic [LUM_W-1:0]        r_lum1;
    logic [LUM_W-1:0]        r_out;

    logic [FACTOR_W-1:0]         n_factor;
    logic [LUM_W+FACTOR_W-1:0]   scaled;

    assign st[2]   = r_v[2] && i_stall;
    assign st[1]   = r_v[1] && st[2];
    assign st[0]   = r_v[0] && st[1];
    assign o_stall = st[0];

    assign n_factor = r_far ? FACTOR_FAR
                            : FACTOR_ONE - r_prod[SLOPE_SHIFT +: FACTOR_W];
    assign scaled   = (LUM_W+FACTOR_W)'(r_lum1) * (LUM_W+FACTOR_W)'(r_factor);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (!st[0]) r_v[0] <= i_valid;
            if (!st[1]) r_v[1] <= r_v[0];
            if (!st[2]) r_v[2] <= r_v[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!st[0]) begin
            r_prod <= SLOPE_PROD_W'(i_root) * SLOPE_PROD_W'(SLOPE_RECIP);
            r_far  <= i_far;
            r_lum0 <= i_lum;
        end
        if (!st[1]) begin
            r_factor <= n_factor;
            r_lum1   <= r_lum0;
        end
        if (!st[2]) begin
            r_out <= scaled[FACTOR_SHIFT +: LUM_W];
        end
    end

    assign o_valid = r_v[2];
    assign o_lum   = r_out;

endmodule

### src/radial_spotlight_luminance.sv
// ----------------------------------------------------------------------------
// radial_spotlight_luminance: radial linear spotlight on pixel luminance
// Scales each pixel's Q1.16 luminance by 1 - 0.005 * distance from the
// configured center, or by 0.2 beyond a distance of 160.
// ----------------------------------------------------------------------------
// Usage:
// - Input channel: i_valid / o_stall with i_pixel_x, i_pixel_y, i_lum_in.
//   A transfer happens on a rising edge with i_valid high and o_stall low.
// - Output channel: o_valid / i_stall with o_lum_out, one result per pixel,
//   in input order.
// - Configuration: i_cfg_we writes i_cfg_data into the register picked by
//   i_cfg_index (center x, center y). Write only while the block is empty.
// - The pipeline has the offset, square and sum stages, sixteen
//   square-root cells (one root bit each), and the factor, subtract and
//   scale stages. Every stage takes a new pixel each cycle while the
//   receiver does not stall, so the throughput is one pixel per clock.
// - When the receiver stalls, the full stages hold and empty stages ahead
//   of them keep filling; o_stall rises only once the whole chain is full.
// - Synchronous reset empties the pipeline and sets the center to (0, 0).
// ----------------------------------------------------------------------------
module radial_spotlight_luminance
    import rsl_pkg::*;
#(
    parameter int COORD_WIDTH   = 12,
    parameter int LUM_FRAC_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [0:0]               i_cfg_index,
    input  logic [CFG_W-1:0]         i_cfg_data,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [COORD_WIDTH-1:0]   i_pixel_x,
    input  logic [COORD_WIDTH-1:0]   i_pixel_y,
    input  logic [LUM_FRAC_BITS:0]   i_lum_in,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [LUM_FRAC_BITS:0]   o_lum_out
);

    localparam int LUM_W = LUM_FRAC_BITS + 1;

    logic signed [CFG_W-1:0] r_center_x;
    logic signed [CFG_W-1:0] r_center_y;

    logic             chain_valid [0:ROOT_W];
    logic             chain_stall [0:ROOT_W];
    logic [LUM_W-1:0] chain_lum   [0:ROOT_W];
    t_root_data       chain_data  [0:ROOT_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x <= '0;
            r_center_y <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_CENTER_X: r_center_x <= i_cfg_data;
                CFG_CENTER_Y: r_center_y <= i_cfg_data;
                default: ;
            endcase
        end
    end

    rsl_front #(
        .COORD_W (COORD_WIDTH),
        .LUM_W   (LUM_W)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_center_x (r_center_x),
        .i_center_y (r_center_y),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_pixel_x  (i_pixel_x),
        .i_pixel_y  (i_pixel_y),
        .i_lum      (i_lum_in),
        .o_valid    (chain_valid[0]),
        .i_stall    (chain_stall[0]),
        .o_lum      (chain_lum[0]),
        .o_data     (chain_data[0])
    );

    for (genvar g = 0; g < ROOT_W; g++) begin : g_cell
        rsl_root_cell #(
            .LUM_W (LUM_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (chain_valid[g]),
            .o_stall (chain_stall[g]),
            .i_lum   (chain_lum[g]),
            .i_data  (chain_data[g]),
            .o_valid (chain_valid[g+1]),
            .i_stall (chain_stall[g+1]),
            .o_lum   (chain_lum[g+1]),
            .o_data  (chain_data[g+1])
        );
    end

    rsl_back #(
        .LUM_W (LUM_W)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (chain_valid[ROOT_W]),
        .o_stall (chain_stall[ROOT_W]),
        .i_lum   (chain_lum[ROOT_W]),
        .i_far   (chain_data[ROOT_W].far),
        .i_root  (chain_data[ROOT_W].root),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_lum   (o_lum_out)
    );

`ifndef SYNTHESIS
    // The input side can only be held back once the result register is full
    // and the receiver is stalling.
    a_stall_needs_full_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled while the output side can move");

    // A near pixel has distance at most 160.0 in Q8.8.
    a_root_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (chain_valid[ROOT_W] && !chain_data[ROOT_W].far)
            |-> (chain_data[ROOT_W].root <= ROOT_W'(40960)))
        else $error("square root of a near pixel exceeds 160.0");

    // A held result at the chain end stays put while the back end is full and stalled.
    a_chain_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (chain_valid[ROOT_W] && chain_stall[ROOT_W])
            |=> (chain_valid[ROOT_W] && $stable(chain_data[ROOT_W])))
        else $error("square-root result changed while held");
`endif

endmodule
